>>> hw/rtl/comment_lane_allocator_defines.svh
// assertion macros for the comment lane allocator rtl
`ifndef COMMENT_LANE_ALLOCATOR_DEFINES_SVH
`define COMMENT_LANE_ALLOCATOR_DEFINES_SVH

// same-cycle implication, checked on clk_i, off during reset
`define CLA_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("cla assertion failed");

// next-cycle implication, checked on clk_i, off during reset
`define CLA_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("cla assertion failed");

`endif

>>> hw/rtl/cla_pkg.sv
// types, constants and helpers of the comment lane allocator
package cla_pkg;

  localparam int MAX_LANES = 32;
  localparam int LANE_W    = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int CNT_W     = $clog2(MAX_LANES + 1);

  localparam int TIME_W    = 32;
  localparam int LEN_W     = 12;
  localparam int SW_W      = 13;
  localparam int DUR_W     = 16;
  localparam int LCNT_W    = 6;
  localparam int LVL_W     = 4;
  localparam int MASK_W    = 4;
  localparam int OUT_LANE_W = 5;

  // divider geometry: numerator is width * duration, denominator width + length
  localparam int NUM_W     = SW_W + DUR_W;
  localparam int DEN_W     = SW_W + 1;
  localparam int QUO_W     = DUR_W;
  localparam int DCNT_W    = $clog2(NUM_W + 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int IN_DATA_W  = 88;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 3;

  // reset values of the configuration registers
  localparam logic [LCNT_W-1:0] RST_LANE_COUNT = LCNT_W'(20);
  localparam logic [SW_W-1:0]   RST_SCREEN_W   = SW_W'(1280);
  localparam logic [DUR_W-1:0]  RST_SCROLL_DUR = DUR_W'(12000);
  localparam logic [DUR_W-1:0]  RST_CENTER_DUR = DUR_W'(4000);
  localparam logic [LVL_W-1:0]  RST_MIN_LEVEL  = LVL_W'(0);
  localparam logic [MASK_W-1:0] RST_SHOW_MASK  = MASK_W'(15);

  // show mask bit positions
  localparam int MASK_TOP    = 0;
  localparam int MASK_BOTTOM = 1;
  localparam int MASK_SCROLL = 2;
  localparam int MASK_COLOUR = 3;

  typedef enum logic [1:0] {
    KIND_SCROLL  = 2'd0,
    KIND_BOTTOM  = 2'd1,
    KIND_TOP     = 2'd2,
    KIND_INVALID = 2'd3
  } cla_kind_e;

  typedef enum logic [2:0] {
    STS_PLACED  = 3'd0,
    STS_EXPIRED = 3'd1,
    STS_LEVEL   = 3'd2,
    STS_TYPE    = 3'd3,
    STS_COLOUR  = 3'd4,
    STS_INVALID = 3'd5,
    STS_NOLANE  = 3'd6
  } cla_status_e;

  typedef enum logic [2:0] {
    REG_LANE_COUNT = 3'd0,
    REG_SCREEN_W   = 3'd1,
    REG_SCROLL_DUR = 3'd2,
    REG_CENTER_DUR = 3'd3,
    REG_MIN_LEVEL  = 3'd4,
    REG_SHOW_MASK  = 3'd5
  } cla_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILTER,
    S_DIV,
    S_TIMES,
    S_SCAN,
    S_DONE
  } cla_state_e;

  // controller to datapath
  typedef struct packed {
    logic        load;
    logic        div_start;
    logic        times_en;
    logic        scan_init;
    logic        scan_en;
    logic        mem_wr;
    logic        set_res;
    cla_status_e res_code;
    logic        out_load;
  } cla_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic        filt_pass;
    cla_status_e filt_code;
    logic        is_center;
    logic        no_lanes;
    logic        div_done;
    logic        hit;
    logic        scan_end;
  } cla_sts_t;

  // time plus a duration, saturating at the top of the time range
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                input logic [DUR_W-1:0] v);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W + 1 - DUR_W){1'b0}}, v};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

>>> hw/rtl/cla_div.sv
// restoring radix-2 divider, one quotient bit per cycle
module cla_div
  import cla_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] numer_i,
  input  logic [DEN_W-1:0] denom_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]  num_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic              den_zero_q;

  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // trial subtract of the next numerator bit
  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - DCNT_W'(1);
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q      <= numer_i;
      rem_q      <= '0;
      den_q      <= denom_i;
      den_zero_q <= (denom_i == '0);
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  // quotient never exceeds the duration, so its low bits are the whole value
  assign done_o = !busy_q;
  assign quot_o = den_zero_q ? '0 : num_q[QUO_W-1:0];

endmodule

>>> hw/rtl/cla_datapath.sv
// item registers, filters, lane time stores and lane scan of the allocator
module cla_datapath
  import cla_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  // input item payload
  input  logic [IN_DATA_W-1:0]  s_data_i,
  input  logic [IN_USER_W-1:0]  s_user_i,
  // result payload
  output logic [OUT_DATA_W-1:0] m_data_o,
  output logic [OUT_USER_W-1:0] m_user_o,
  // controller link
  input  cla_cmd_t              cmd_i,
  output cla_sts_t              sts_o
);

  // configuration registers
  logic [LCNT_W-1:0] lane_count_q;
  logic [SW_W-1:0]   screen_w_q;
  logic [DUR_W-1:0]  scroll_dur_q;
  logic [DUR_W-1:0]  center_dur_q;
  logic [LVL_W-1:0]  min_level_q;
  logic [MASK_W-1:0] show_mask_q;
  cla_reg_e          cfg_reg;

  assign cfg_reg = cla_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_count_q <= RST_LANE_COUNT;
      screen_w_q   <= RST_SCREEN_W;
      scroll_dur_q <= RST_SCROLL_DUR;
      center_dur_q <= RST_CENTER_DUR;
      min_level_q  <= RST_MIN_LEVEL;
      show_mask_q  <= RST_SHOW_MASK;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg)
        REG_LANE_COUNT: lane_count_q <= cfg_data_i[LCNT_W-1:0];
        REG_SCREEN_W:   screen_w_q   <= cfg_data_i[SW_W-1:0];
        REG_SCROLL_DUR: scroll_dur_q <= cfg_data_i[DUR_W-1:0];
        REG_CENTER_DUR: center_dur_q <= cfg_data_i[DUR_W-1:0];
        REG_MIN_LEVEL:  min_level_q  <= cfg_data_i[LVL_W-1:0];
        REG_SHOW_MASK:  show_mask_q  <= cfg_data_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [TIME_W-1:0] t_q;
  logic [TIME_W-1:0] play_q;
  cla_kind_e         kind_q;
  logic [LVL_W-1:0]  level_q;
  logic              white_q;
  logic [LEN_W-1:0]  len_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q     <= s_data_i[31:0];
      play_q  <= s_data_i[63:32];
      level_q <= s_data_i[67:64];
      white_q <= s_data_i[68];
      len_q   <= s_data_i[80:69];
      kind_q  <= cla_kind_e'(s_user_i);
    end
  end

  // usable lane count, clamped to the store depth
  logic [CNT_W-1:0] lanes;
  always_comb begin
    if (int'(lane_count_q) > MAX_LANES) begin
      lanes = CNT_W'(MAX_LANES);
    end else begin
      lanes = CNT_W'(lane_count_q);
    end
  end

  // expiry and filter chain
  logic              is_center;
  logic [DUR_W-1:0]  life_dur;
  logic [TIME_W:0]   end_time;
  logic              type_ok;
  cla_status_e       filt_code;

  always_comb begin
    is_center = (kind_q == KIND_BOTTOM) || (kind_q == KIND_TOP);
    life_dur  = is_center ? center_dur_q : scroll_dur_q;
    end_time  = {1'b0, t_q} + {{(TIME_W + 1 - DUR_W){1'b0}}, life_dur};
    case (kind_q)
      KIND_BOTTOM: type_ok = show_mask_q[MASK_BOTTOM];
      KIND_TOP:    type_ok = show_mask_q[MASK_TOP];
      default:     type_ok = show_mask_q[MASK_SCROLL];
    endcase
    if (end_time < {1'b0, play_q}) begin
      filt_code = STS_EXPIRED;
    end else if (level_q < min_level_q) begin
      filt_code = STS_LEVEL;
    end else if (!type_ok) begin
      filt_code = STS_TYPE;
    end else if (!white_q && !show_mask_q[MASK_COLOUR]) begin
      filt_code = STS_COLOUR;
    end else if (kind_q == KIND_INVALID) begin
      filt_code = STS_INVALID;
    end else begin
      filt_code = STS_PLACED;
    end
  end

  // scroll timing: two divisions by width plus length, run side by side
  logic [LEN_W+DUR_W-1:0] prod_enter;
  logic [SW_W+DUR_W-1:0]  prod_left;
  logic [DEN_W-1:0]       denom;
  logic                   enter_done;
  logic                   left_done;
  logic [QUO_W-1:0]       enter_quot;
  logic [QUO_W-1:0]       left_quot;

  assign prod_enter = len_q * scroll_dur_q;
  assign prod_left  = screen_w_q * scroll_dur_q;
  assign denom      = DEN_W'(screen_w_q) + DEN_W'(len_q);

  cla_div u_div_enter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .numer_i (NUM_W'(prod_enter)),
    .denom_i (denom),
    .done_o  (enter_done),
    .quot_o  (enter_quot)
  );

  cla_div u_div_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .numer_i (NUM_W'(prod_left)),
    .denom_i (denom),
    .done_o  (left_done),
    .quot_o  (left_quot)
  );

  // absolute scroll times
  logic [TIME_W-1:0] enter_t_q;
  logic [TIME_W-1:0] left_t_q;
  logic [TIME_W-1:0] exit_t_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.times_en) begin
      enter_t_q <= sat_add(t_q, enter_quot);
      left_t_q  <= sat_add(t_q, left_quot);
      exit_t_q  <= sat_add(t_q, scroll_dur_q);
    end
  end

  // lane scan: one read issued and one lane judged per cycle
  logic [CNT_W-1:0]  k_q;
  logic              pend_q;
  logic [LANE_W-1:0] pend_lane_q;
  logic              issue;
  logic [CNT_W-1:0]  lane_pos;
  logic [LANE_W-1:0] rd_addr;

  always_comb begin
    issue = cmd_i.scan_en && (k_q < lanes);
    if (kind_q == KIND_BOTTOM) begin
      lane_pos = lanes - CNT_W'(1) - k_q;
    end else begin
      lane_pos = k_q;
    end
    rd_addr = lane_pos[LANE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.scan_init) begin
      k_q    <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.scan_en) begin
      pend_q <= issue;
      if (issue) begin
        k_q <= k_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      pend_lane_q <= rd_addr;
    end
  end

  // lane time stores; an entry never written reads as zero
  logic [TIME_W-1:0]    center_mem [MAX_LANES];
  logic [TIME_W-1:0]    enter_mem  [MAX_LANES];
  logic [TIME_W-1:0]    exit_mem   [MAX_LANES];
  logic [MAX_LANES-1:0] c_valid_q;
  logic [MAX_LANES-1:0] s_valid_q;
  logic [TIME_W-1:0]    c_rd_q;
  logic [TIME_W-1:0]    e_rd_q;
  logic [TIME_W-1:0]    x_rd_q;
  logic                 c_vld_rd_q;
  logic                 s_vld_rd_q;
  logic                 wr_center;
  logic                 wr_scroll;

  assign wr_center = cmd_i.mem_wr && is_center;
  assign wr_scroll = cmd_i.mem_wr && !is_center;

  always_ff @(posedge clk_i) begin
    if (wr_center) begin
      center_mem[pend_lane_q] <= sat_add(t_q, center_dur_q);
    end
    if (wr_scroll) begin
      enter_mem[pend_lane_q] <= enter_t_q;
      exit_mem[pend_lane_q]  <= exit_t_q;
    end
    if (issue) begin
      c_rd_q     <= center_mem[rd_addr];
      e_rd_q     <= enter_mem[rd_addr];
      x_rd_q     <= exit_mem[rd_addr];
      c_vld_rd_q <= c_valid_q[rd_addr];
      s_vld_rd_q <= s_valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= '0;
      s_valid_q <= '0;
    end else begin
      if (wr_center) begin
        c_valid_q[pend_lane_q] <= 1'b1;
      end
      if (wr_scroll) begin
        s_valid_q[pend_lane_q] <= 1'b1;
      end
    end
  end

  // judge the lane whose times came back this cycle
  logic [TIME_W-1:0] c_val;
  logic [TIME_W-1:0] e_val;
  logic [TIME_W-1:0] x_val;
  logic              usable;

  always_comb begin
    c_val = c_vld_rd_q ? c_rd_q : '0;
    e_val = s_vld_rd_q ? e_rd_q : '0;
    x_val = s_vld_rd_q ? x_rd_q : '0;
    if (is_center) begin
      usable = (t_q >= c_val);
    end else begin
      usable = (t_q >= e_val) && (left_t_q >= x_val);
    end
  end

  // result and output registers
  cla_status_e           res_status_q;
  logic [OUT_LANE_W-1:0] res_lane_q;
  cla_status_e           out_status_q;
  logic [OUT_LANE_W-1:0] out_lane_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_code;
      res_lane_q   <= (cmd_i.res_code == STS_PLACED) ? OUT_LANE_W'(pend_lane_q) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_lane_q   <= res_lane_q;
    end
  end

  assign m_data_o = {{(OUT_DATA_W - OUT_LANE_W){1'b0}}, out_lane_q};
  assign m_user_o = out_status_q;

  // status to the controller
  always_comb begin
    sts_o.filt_pass = (filt_code == STS_PLACED);
    sts_o.filt_code = filt_code;
    sts_o.is_center = is_center;
    sts_o.no_lanes  = (lanes == '0);
    sts_o.div_done  = enter_done && left_done;
    sts_o.hit       = pend_q && usable;
    sts_o.scan_end  = !pend_q && !(k_q < lanes);
  end

endmodule

>>> hw/rtl/cla_ctrl.sv
// sequencer of the allocator: filter, divide, scan and result hand-off
`include "comment_lane_allocator_defines.svh"

module cla_ctrl
  import cla_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  output logic     s_tready_o,
  output logic     m_tvalid_o,
  input  logic     m_tready_i,
  input  cla_sts_t sts_i,
  output cla_cmd_t cmd_o
);

  cla_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;
  logic       out_free;

  assign in_xfer  = s_tvalid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || m_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          state_d = S_FILTER;
        end
      end
      S_FILTER: begin
        if (!sts_i.filt_pass || sts_i.no_lanes) begin
          state_d = S_DONE;
        end else if (sts_i.is_center) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_TIMES;
        end
      end
      S_TIMES: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.hit || sts_i.scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.res_code = STS_PLACED;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = s_tvalid_i;
      end
      S_FILTER: begin
        if (!sts_i.filt_pass) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = sts_i.filt_code;
        end else if (sts_i.no_lanes) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STS_NOLANE;
        end else if (sts_i.is_center) begin
          cmd_o.scan_init = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      S_DIV: ;
      S_TIMES: begin
        cmd_o.times_en  = 1'b1;
        cmd_o.scan_init = 1'b1;
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.hit) begin
          cmd_o.mem_wr   = 1'b1;
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STS_PLACED;
        end else if (sts_i.scan_end) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = STS_NOLANE;
        end
      end
      S_DONE: begin
        cmd_o.out_load = out_free;
      end
      default: ;
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == S_DONE) && out_free) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = out_valid_q;

  // an accepted item is filtered in the very next cycle
  `CLA_ASSERT_NEXT(a_accept_to_filter, in_xfer, state_q == S_FILTER)
  // a found lane ends the scan at once
  `CLA_ASSERT_NEXT(a_hit_ends_scan, (state_q == S_SCAN) && sts_i.hit, state_q == S_DONE)
  // a finished result reaches the output register and frees the block
  `CLA_ASSERT_NEXT(a_done_hands_off, (state_q == S_DONE) && out_free,
                   out_valid_q && (state_q == S_IDLE))
  // no lane is written outside the scan
  `CLA_ASSERT_NOW(a_write_in_scan, cmd_o.mem_wr, state_q == S_SCAN)

endmodule

>>> hw/rtl/comment_lane_allocator.sv
// top level of the comment lane allocator
// one item at a time; a filtered or expired comment passes from the filter to the result
// top and bottom comments scan the lanes until a free one is found or all are scanned
// scrolling comments first run the two parallel 29-step restoring dividers and then
// form their times before the scan; the next transfer follows the result into the output
// register; async reset clears control and configuration state and lane valid bits
module comment_lane_allocator
  import cla_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // fields: comment_time_ms[31:0], playback_ms[63:32], level[67:64],
  // plain_white[68], text_length[80:69], zero fill[87:81]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // fields: kind[1:0]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // fields: lane[4:0], zero fill[7:5]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // fields: status[2:0]
  output logic [OUT_USER_W-1:0] m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i
);

  cla_cmd_t cmd;
  cla_sts_t sts;

  // configuration writes are taken in any cycle
  assign cfg_ready_o = 1'b1;

  cla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cla_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

>>> bench/tb.sv
// self-checking bench for the comment lane allocator: directed table, then random phases
module tb
  import cla_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASES         = 8;
  localparam int PER_PHASE      = 85;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;

  // register indexes past the last register, ignored by the block
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [31:0] ctime;
    logic [31:0] play;
    cla_kind_e   kind;
    logic [3:0]  level;
    logic        white;
    logic [11:0] len;
  } comment_t;

  typedef struct {
    cla_status_e status;
    logic [4:0]  lane;
  } placement_t;

  typedef struct {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    comment_t             c;
    logic                 typed;
    placement_t           want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]      cfg_data_i;

  // predictor copy of the registers and lane stores
  logic [5:0]  lane_count_r;
  logic [12:0] width_r;
  logic [15:0] scroll_r;
  logic [15:0] center_r;
  logic [3:0]  min_level_r;
  logic [3:0]  mask_r;
  logic [31:0] center_busy_until [MAX_LANES];
  logic [31:0] scroll_entered_at [MAX_LANES];
  logic [31:0] scroll_clear_at   [MAX_LANES];

  placement_t pending_placements[$];
  placement_t seen_want;
  row_t       script[$];

  int  fail_count;
  int  idle_cycles;
  int  comments_sent;
  int  reg_writes;
  int  status_seen[7];
  int  stall_left;
  bit  smooth;
  bit  hold_request;

  comment_lane_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // time value clipped at the top of the 32-bit range
  function automatic logic [31:0] clip_time(input logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // expected outcome of one comment, updating the lane stores on placement
  function automatic placement_t place_comment(input comment_t c);
    placement_t  r;
    logic        centre;
    logic        found;
    int          lanes;
    int          ln;
    logic [32:0] last_ms;
    logic [63:0] d;
    logic [63:0] enter_q;
    logic [63:0] left_q;
    logic [31:0] enter_t;
    logic [31:0] left_t;
    r.status = STS_NOLANE;
    r.lane   = '0;
    found    = 1'b0;
    centre   = (c.kind == KIND_BOTTOM) || (c.kind == KIND_TOP);
    lanes    = (lane_count_r > MAX_LANES) ? MAX_LANES : int'(lane_count_r);
    last_ms  = {1'b0, c.ctime} + (centre ? 33'(center_r) : 33'(scroll_r));
    if (last_ms < {1'b0, c.play}) begin
      r.status = STS_EXPIRED;
    end else if (c.level < min_level_r) begin
      r.status = STS_LEVEL;
    end else if ((c.kind == KIND_BOTTOM && !mask_r[MASK_BOTTOM]) ||
                 (c.kind == KIND_TOP && !mask_r[MASK_TOP]) ||
                 (!centre && !mask_r[MASK_SCROLL])) begin
      r.status = STS_TYPE;
    end else if (!c.white && !mask_r[MASK_COLOUR]) begin
      r.status = STS_COLOUR;
    end else if (c.kind == KIND_INVALID) begin
      r.status = STS_INVALID;
    end else if (centre) begin
      // bottom searches up from the last lane, top down from lane 0
      for (int k = 0; k < lanes; k++) begin
        ln = (c.kind == KIND_BOTTOM) ? lanes - 1 - k : k;
        if (!found && c.ctime >= center_busy_until[ln]) begin
          center_busy_until[ln] = clip_time(64'(c.ctime) + 64'(center_r));
          found    = 1'b1;
          r.status = STS_PLACED;
          r.lane   = ln[4:0];
        end
      end
    end else begin
      // scroll timing from width and text length
      d       = 64'(width_r) + 64'(c.len);
      enter_q = (d == 0) ? 64'd0 : (64'(c.len) * 64'(scroll_r)) / d;
      left_q  = (d == 0) ? 64'd0 : (64'(width_r) * 64'(scroll_r)) / d;
      enter_t = clip_time(64'(c.ctime) + enter_q);
      left_t  = clip_time(64'(c.ctime) + left_q);
      for (int k = 0; k < lanes; k++) begin
        if (!found && c.ctime >= scroll_entered_at[k] && left_t >= scroll_clear_at[k]) begin
          scroll_entered_at[k] = enter_t;
          scroll_clear_at[k]   = clip_time(64'(c.ctime) + 64'(scroll_r));
          found    = 1'b1;
          r.status = STS_PLACED;
          r.lane   = k[4:0];
        end
      end
    end
    return r;
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (smooth || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] data);
    row_t r;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    r.typed  = 1'b0;
    return r;
  endfunction

  function automatic row_t comment_row(input logic [31:0] ct, input logic [31:0] pb,
                                       input cla_kind_e k, input logic [3:0] lvl,
                                       input logic w, input logic [11:0] len,
                                       input logic typed, input cla_status_e st,
                                       input logic [4:0] ln);
    row_t r;
    r.is_reg   = 1'b0;
    r.idx      = '0;
    r.data     = '0;
    r.c.ctime  = ct;
    r.c.play   = pb;
    r.c.kind   = k;
    r.c.level  = lvl;
    r.c.white  = w;
    r.c.len    = len;
    r.typed    = typed;
    r.want.status = st;
    r.want.lane   = ln;
    return r;
  endfunction

  // one comment transfer; the result is predicted at acceptance
  task automatic send_comment(input comment_t c, input int gap, input logic typed,
                              input placement_t typed_result);
    placement_t p;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, c.len, c.white, c.level, c.play, c.ctime};
    s_axis_tuser  <= c.kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = place_comment(c);
    if (typed) begin
      pending_placements.push_back(typed_result);
    end else begin
      pending_placements.push_back(p);
    end
    status_seen[int'(p.status)]++;
    comments_sent++;
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_placements.size() != 0) @(negedge clk_i);
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_LANE_COUNT: lane_count_r = data[5:0];
      REG_SCREEN_W:   width_r      = data[12:0];
      REG_SCROLL_DUR: scroll_r     = data[15:0];
      REG_CENTER_DUR: center_r     = data[15:0];
      REG_MIN_LEVEL:  min_level_r  = data[3:0];
      REG_SHOW_MASK:  mask_r       = data[3:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result receiver: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = draw_gap();
      end
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_placements.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual status %0d lane %0d",
                 $time, m_axis_tuser, m_axis_tdata[4:0]);
      end else begin
        seen_want = pending_placements.pop_front();
        if (m_axis_tuser != seen_want.status) begin
          fail_count++;
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, seen_want.status, m_axis_tuser);
        end
        if (m_axis_tdata[4:0] != seen_want.lane) begin
          fail_count++;
          $display("%0t: lane mismatch, expected %0d actual %0d",
                   $time, seen_want.lane, m_axis_tdata[4:0]);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_placements.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    comment_t    c;
    placement_t  none;
    row_t        row;
    logic [31:0] cursor;
    logic [31:0] dur;
    logic [63:0] step;
    int          r;
    int          noise_pct;
    int          lc;
    int          sw;
    int          sd;
    int          cd;
    int          ml;
    int          sm;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    fail_count    = 0;
    idle_cycles   = 0;
    comments_sent = 0;
    reg_writes    = 0;
    smooth        = 1'b0;
    hold_request  = 1'b0;
    none.status   = STS_PLACED;
    none.lane     = '0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // predictor at its reset state
    lane_count_r = RST_LANE_COUNT;
    width_r      = RST_SCREEN_W;
    scroll_r     = RST_SCROLL_DUR;
    center_r     = RST_CENTER_DUR;
    min_level_r  = RST_MIN_LEVEL;
    mask_r       = RST_SHOW_MASK;
    foreach (center_busy_until[i]) begin
      center_busy_until[i] = '0;
      scroll_entered_at[i] = '0;
      scroll_clear_at[i]   = '0;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table, reset register values first
    script.push_back(comment_row(0, 0, KIND_SCROLL, 0, 1, 0, 1, STS_PLACED, 0));
    script.push_back(comment_row(0, 0, KIND_TOP, 0, 1, 0, 1, STS_PLACED, 0));
    script.push_back(comment_row(0, 0, KIND_BOTTOM, 0, 1, 0, 1, STS_PLACED, 19));
    script.push_back(comment_row(0, 0, KIND_TOP, 0, 1, 0, 1, STS_PLACED, 1));
    script.push_back(comment_row(0, 12001, KIND_SCROLL, 0, 1, 0, 1, STS_EXPIRED, 0));
    script.push_back(comment_row(0, 12000, KIND_SCROLL, 0, 1, 4095, 0, STS_PLACED, 0));
    script.push_back(comment_row(100, 4101, KIND_TOP, 0, 1, 0, 1, STS_EXPIRED, 0));
    script.push_back(comment_row(100, 4100, KIND_BOTTOM, 0, 1, 0, 0, STS_PLACED, 0));
    script.push_back(comment_row(0, 32'hFFFF_FFFF, KIND_TOP, 15, 0, 4095, 1, STS_EXPIRED, 0));
    // level filter, with junk above the register width
    script.push_back(reg_row(REG_MIN_LEVEL, 16'hFFF5));
    script.push_back(comment_row(1000, 1000, KIND_SCROLL, 4, 1, 0, 1, STS_LEVEL, 0));
    script.push_back(comment_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_SCROLL, 4, 0, 4095, 1,
                                 STS_LEVEL, 0));
    // everything hidden
    script.push_back(reg_row(REG_SHOW_MASK, 16'hFFF0));
    script.push_back(comment_row(20000, 20000, KIND_TOP, 10, 1, 0, 1, STS_TYPE, 0));
    script.push_back(comment_row(20000, 20000, KIND_BOTTOM, 10, 1, 0, 1, STS_TYPE, 0));
    script.push_back(comment_row(20000, 20000, KIND_INVALID, 10, 1, 0, 1, STS_TYPE, 0));
    // scroll only, coloured comments hidden
    script.push_back(reg_row(REG_SHOW_MASK, 16'h0004));
    script.push_back(comment_row(20000, 20000, KIND_SCROLL, 10, 0, 100, 1, STS_COLOUR, 0));
    script.push_back(comment_row(20000, 20000, KIND_INVALID, 10, 1, 100, 1, STS_INVALID, 0));
    script.push_back(comment_row(20000, 20000, KIND_INVALID, 10, 0, 100, 1, STS_COLOUR, 0));
    script.push_back(comment_row(20000, 20000, KIND_TOP, 10, 1, 100, 1, STS_TYPE, 0));
    // no lanes at all; spare indexes leave it so
    script.push_back(reg_row(REG_LANE_COUNT, 16'hFFC0));
    script.push_back(comment_row(50000, 50000, KIND_SCROLL, 10, 1, 10, 1, STS_NOLANE, 0));
    script.push_back(reg_row(REG_SPARE_LO, 16'h0001));
    script.push_back(reg_row(REG_SPARE_HI, 16'hFFFF));
    script.push_back(comment_row(50000, 50000, KIND_SCROLL, 10, 1, 10, 1, STS_NOLANE, 0));
    // lane count above the maximum, zero width, extreme durations
    script.push_back(reg_row(REG_LANE_COUNT, 16'h003F));
    script.push_back(reg_row(REG_SCREEN_W, 16'h2000));
    script.push_back(reg_row(REG_SCROLL_DUR, 16'hFFFF));
    script.push_back(reg_row(REG_CENTER_DUR, 16'h0001));
    script.push_back(reg_row(REG_MIN_LEVEL, 16'h0000));
    script.push_back(reg_row(REG_SHOW_MASK, 16'h000F));
    script.push_back(comment_row(60000, 60000, KIND_SCROLL, 0, 1, 0, 0, STS_PLACED, 0));
    script.push_back(comment_row(60000, 60000, KIND_SCROLL, 0, 1, 4095, 0, STS_PLACED, 0));
    script.push_back(comment_row(60000, 60000, KIND_BOTTOM, 0, 1, 0, 0, STS_PLACED, 0));
    script.push_back(comment_row(60000, 60000, KIND_TOP, 0, 1, 0, 0, STS_PLACED, 0));

    foreach (script[i]) begin
      row = script[i];
      if (row.is_reg) begin
        wait_drained();
        write_reg(row.idx, row.data);
      end else begin
        send_comment(row.c, draw_gap(), row.typed, row.want);
      end
    end

    // random phases, each under its own register setting
    cursor = 32'h0010_0000;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin lc = 20; sw = 1280; sd = 12000; cd = 4000; ml = 0; sm = 15; end
        1: begin lc = 1; sw = 1; sd = 1; cd = 1; ml = 0; sm = 15; end
        2: begin lc = 32; sw = 4096; sd = 65535; cd = 65535; ml = 10; sm = 15; end
        default: begin
          r  = $urandom_range(0, 99);
          lc = (r < 85) ? $urandom_range(1, 32) : (r < 95) ? $urandom_range(33, 63) : 0;
          sw = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 4096) : $urandom_range(0, 8191);
          r  = $urandom_range(0, 99);
          sd = (r < 80) ? $urandom_range(300, 20000) :
               (r < 90) ? $urandom_range(1, 50) : $urandom_range(20000, 65535);
          r  = $urandom_range(0, 99);
          cd = (r < 80) ? $urandom_range(300, 20000) :
               (r < 90) ? $urandom_range(1, 50) : $urandom_range(20000, 65535);
          ml = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 15);
          sm = ($urandom_range(0, 99) < 60) ? 15 : $urandom_range(0, 15);
        end
      endcase
      write_reg(REG_LANE_COUNT, 16'(lc) | (16'($urandom) & 16'hFFC0));
      write_reg(REG_SCREEN_W, 16'(sw) | (16'($urandom) & 16'hE000));
      write_reg(REG_SCROLL_DUR, 16'(sd));
      write_reg(REG_CENTER_DUR, 16'(cd));
      write_reg(REG_MIN_LEVEL, 16'(ml) | (16'($urandom) & 16'hFFF0));
      write_reg(REG_SHOW_MASK, 16'(sm) | (16'($urandom) & 16'hFFF0));
      if (ph >= 3) write_reg(ph[0] ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));

      // later phases jump ahead in time, the last one up against the top of the range
      if (ph == PHASES - 1) cursor = 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
      else cursor = cursor + 32'($urandom_range(32'h0010_0000, 32'h1000_0000));
      noise_pct = (ph == PHASES - 1) ? 30 : 8;
      smooth    = (ph == 3);

      for (int n = 0; n < PER_PHASE; n++) begin
        // long receiver hold-off while the sender keeps offering
        if (ph == 4 && n == 20) hold_request = 1'b1;
        // sender pause until everything is back
        if (ph == 5 && n == 40) wait_drained();

        r = $urandom_range(0, 99);
        if (r < 65) step = $urandom_range(0, 64 + scroll_r / 16);
        else if (r < 95) step = $urandom_range(0, 64 + scroll_r / 2);
        else step = $urandom_range(0, 64 + 4 * scroll_r);
        cursor = (64'(cursor) + step > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cursor + step[31:0];

        // comment in time order with random content
        r = $urandom_range(0, 99);
        c.kind  = (r < 45) ? KIND_SCROLL : (r < 67) ? KIND_TOP : (r < 89) ? KIND_BOTTOM :
                  (r < 93) ? KIND_INVALID : cla_kind_e'($urandom_range(0, 3));
        c.ctime = cursor;
        c.level = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(min_level_r, 10)) :
                  4'($urandom_range(0, 15));
        c.white = ($urandom_range(0, 99) < 80);
        c.len   = 12'($urandom_range(0, 4095));
        dur = (c.kind == KIND_TOP || c.kind == KIND_BOTTOM) ? 32'(center_r) : 32'(scroll_r);
        r = $urandom_range(0, 99);
        if (r < 65) c.play = c.ctime + 32'($urandom_range(0, 200));
        else if (r < 77) c.play = c.ctime - 32'($urandom_range(1, 500));
        else if (r < 92) c.play = c.ctime + dur + 32'($urandom_range(0, 2));
        else c.play = $urandom;

        // noise: arbitrary fields
        if ($urandom_range(0, 99) < noise_pct) begin
          c.kind  = cla_kind_e'($urandom_range(0, 3));
          c.level = 4'($urandom_range(0, 15));
          c.white = 1'($urandom_range(0, 1));
          c.play  = $urandom;
          if (ph == PHASES - 1) c.ctime = $urandom;
        end
        send_comment(c, draw_gap(), 1'b0, none);
      end
      smooth = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_placements.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $time, pending_placements.size());
    end

    $display("%0d comments over %0d register writes and %0d random settings",
             comments_sent, reg_writes, PHASES);
    $display("placed %0d expired %0d level %0d type %0d colour %0d invalid %0d no lane %0d",
             status_seen[STS_PLACED], status_seen[STS_EXPIRED], status_seen[STS_LEVEL],
             status_seen[STS_TYPE], status_seen[STS_COLOUR], status_seen[STS_INVALID],
             status_seen[STS_NOLANE]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/cla_pkg.sv
hw/rtl/cla_div.sv
hw/rtl/cla_datapath.sv
hw/rtl/cla_ctrl.sv
hw/rtl/comment_lane_allocator.sv
bench/tb.sv
